FILE: design/lcgss_pkg.sv
// lcgss_pkg: constants, beat payload types and the odd prime table
// for the LCG substream seed setup block. No dependencies.
package lcgss_pkg;

  localparam int unsigned WordW = 32;

  // Base generator x' = BASE_MUL * x + BASE_INC (mod 2^32)
  localparam logic [WordW-1:0] BASE_MUL = 32'd1664525;
  localparam logic [WordW-1:0] BASE_INC = 32'd1013904223;
  localparam logic [WordW-1:0] ALL_ONES = 32'hFFFF_FFFF;

  // Odd prime table for the second generator increment
  localparam int unsigned PRIME_COUNT_DEF = 100;
  localparam int unsigned PrimeDepth      = 100;
  localparam int unsigned PrimeIdxW       = $clog2(PrimeDepth);
  localparam int unsigned PrimeW          = 10;

  localparam logic [PrimeW-1:0] ODD_PRIMES [PrimeDepth] = '{
    10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,  10'd23,  10'd29,  10'd31,
    10'd37,  10'd41,  10'd43,  10'd47,  10'd53,  10'd59,  10'd61,  10'd67,  10'd71,  10'd73,
    10'd79,  10'd83,  10'd89,  10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127,
    10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173, 10'd179,
    10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223, 10'd227, 10'd229, 10'd233,
    10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269, 10'd271, 10'd277, 10'd281, 10'd283,
    10'd293, 10'd307, 10'd311, 10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353,
    10'd359, 10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409, 10'd419,
    10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463, 10'd467,
    10'd479, 10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541, 10'd547
  };

  typedef struct packed {
    logic [WordW-1:0] seed;
    logic [WordW-1:0] sequence_count;
    logic [WordW-1:0] sequence_number;
    logic             leapfrog_mode;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] start_value;
    logic [WordW-1:0] multiplier;
    logic [WordW-1:0] increment;
    logic [WordW-1:0] second_increment;
    logic             bad_request;
  } rsp_t;

  // Entries past the table read as zero
  function automatic logic [PrimeW-1:0] odd_prime(input logic [PrimeIdxW-1:0] idx);
    logic [PrimeW-1:0] val;
    val = '0;
    if (int'(idx) < PrimeDepth) begin
      val = ODD_PRIMES[idx];
    end
    return val;
  endfunction

endpackage

FILE: design/lcgss_stream_if.sv
// lcgss_stream_if: valid/ready channel carrying one payload beat of type T.
// Used with lcgss_pkg::req_t and lcgss_pkg::rsp_t.
interface lcgss_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/lcgss_div.sv
// lcgss_div: restoring divider computing ALL_ONES / divisor, one quotient
// bit per cycle. Depends on lcgss_pkg.
module lcgss_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;   // dividend bits shift out, quotient bits shift in
  logic [31:0] dvs_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= lcgss_pkg::ALL_ONES;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[30:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/lcg_substream_seed_setup.sv
// lcg_substream_seed_setup: starting state of one 32-bit LCG substream.
// Steps to the response beat: leapfrog runs a pass, apply, then a second pass;
// portable runs divide, skip multiply, one pass, apply; rejected goes straight to the beat.
// One request in flight on one shared 32x32 multiply-add, four uses per step bit;
// a new request is taken the cycle after the response beat.
// Reset (rst_ni low, async) returns the sequencer to idle with no response pending.
module lcg_substream_seed_setup #(
  parameter int unsigned PRIME_COUNT = lcgss_pkg::PRIME_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lcgss_stream_if.sink          req_i,
  lcgss_stream_if.source        rsp_o
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;  // waiting on the divider
  localparam logic [2:0] ST_SKIP  = 3'd2;  // skip count = quotient * (id - 1)
  localparam logic [2:0] ST_MAP   = 3'd3;  // square-and-multiply pass
  localparam logic [2:0] ST_APPLY = 3'd4;  // start = ma * seed + mc
  localparam logic [2:0] ST_RESP  = 3'd5;  // response beat held

  // Phases of one step bit in a pass
  localparam logic [1:0] PH_ACC_A = 2'd0;  // acc_a = sa * acc_a      (bit set)
  localparam logic [1:0] PH_ACC_C = 2'd1;  // acc_c = sa * acc_c + sc (bit set)
  localparam logic [1:0] PH_SC    = 2'd2;  // sc    = (sa + 1) * sc
  localparam logic [1:0] PH_SA    = 2'd3;  // sa    = sa * sa

  logic [2:0]  state_q;
  logic [1:0]  phase_q;
  logic [4:0]  bit_q;
  logic        pass_q;     // leapfrog: 0 advances the seed, 1 builds the k-step map

  logic [31:0] seed_q, count_q, id_q;
  logic        leap_q;
  logic [31:0] steps_q;    // remaining step bits, LSB first
  logic [31:0] sa_q, sc_q, acca_q, accc_q;

  logic [31:0] start_q, mul_q, inc_q, inc2_q;
  logic        bad_q;

  logic        accept;
  logic        req_bad;
  logic        div_start;
  logic        div_done;
  logic [31:0] quotient;
  logic        last_bit;

  // Shared multiply-add unit: mac = op_a * op_b + op_c (mod 2^32)
  logic [31:0] op_a, op_b, op_c, mac;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Zero count is always rejected; portable mode also needs 1 <= id <= PRIME_COUNT
  assign req_bad = (req_i.data.sequence_count == '0) ||
                   (!req_i.data.leapfrog_mode &&
                    ((req_i.data.sequence_number == '0) ||
                     (req_i.data.sequence_number > 32'(PRIME_COUNT))));

  assign div_start = accept && !req_bad && !req_i.data.leapfrog_mode;
  assign last_bit  = (phase_q == PH_SA) && (bit_q == 5'd31);

  lcgss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (req_i.data.sequence_count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = '0;
    case (state_q)
      ST_SKIP: begin
        op_a = quotient;
        op_b = id_q - 32'd1;
      end
      ST_APPLY: begin
        op_a = acca_q;
        op_b = seed_q;
        op_c = accc_q;
      end
      ST_MAP: begin
        case (phase_q)
          PH_ACC_A: begin
            op_a = sa_q;
            op_b = acca_q;
          end
          PH_ACC_C: begin
            op_a = sa_q;
            op_b = accc_q;
            op_c = sc_q;
          end
          PH_SC: begin
            op_a = sa_q + 32'd1;
            op_b = sc_q;
          end
          default: begin
            op_a = sa_q;
            op_b = sa_q;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign mac = 32'(op_a * op_b) + op_c;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_ACC_A;
      bit_q   <= '0;
      pass_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            phase_q <= PH_ACC_A;
            bit_q   <= '0;
            pass_q  <= 1'b0;
            if (req_bad) begin
              state_q <= ST_RESP;
            end else if (req_i.data.leapfrog_mode) begin
              state_q <= ST_MAP;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_SKIP;
        end
        ST_SKIP: state_q <= ST_MAP;
        ST_MAP: begin
          phase_q <= phase_q + 2'd1;
          if (phase_q == PH_SA) bit_q <= bit_q + 5'd1;
          if (last_bit) state_q <= pass_q ? ST_RESP : ST_APPLY;
        end
        ST_APPLY: begin
          if (leap_q) begin
            state_q <= ST_MAP;
            pass_q  <= 1'b1;
            phase_q <= PH_ACC_A;
            bit_q   <= '0;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (rsp_o.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          seed_q  <= req_i.data.seed;
          count_q <= req_i.data.sequence_count;
          id_q    <= req_i.data.sequence_number;
          leap_q  <= req_i.data.leapfrog_mode;
          steps_q <= req_i.data.sequence_number;
          sa_q    <= lcgss_pkg::BASE_MUL;
          sc_q    <= lcgss_pkg::BASE_INC;
          acca_q  <= 32'd1;
          accc_q  <= '0;
          start_q <= '0;
          mul_q   <= '0;
          inc_q   <= '0;
          inc2_q  <= '0;
          bad_q   <= req_bad;
        end
      end
      ST_SKIP: steps_q <= mac;
      ST_MAP: begin
        case (phase_q)
          PH_ACC_A: if (steps_q[0]) acca_q <= mac;
          PH_ACC_C: if (steps_q[0]) accc_q <= mac;
          PH_SC:    sc_q <= mac;
          default: begin
            sa_q    <= mac;
            steps_q <= steps_q >> 1;
            // end of the k-step pass: the map is the substream's generator
            if (last_bit && pass_q) begin
              mul_q <= acca_q;
              inc_q <= accc_q;
            end
          end
        endcase
      end
      ST_APPLY: begin
        start_q <= mac;
        if (leap_q) begin
          steps_q <= count_q;
          sa_q    <= lcgss_pkg::BASE_MUL;
          sc_q    <= lcgss_pkg::BASE_INC;
          acca_q  <= 32'd1;
          accc_q  <= '0;
        end else begin
          mul_q  <= lcgss_pkg::BASE_MUL;
          inc_q  <= lcgss_pkg::BASE_INC;
          inc2_q <= 32'(lcgss_pkg::odd_prime(
                      lcgss_pkg::PrimeIdxW'(id_q - 32'd1)));
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid                 = (state_q == ST_RESP);
  assign rsp_o.data.start_value      = start_q;
  assign rsp_o.data.multiplier       = mul_q;
  assign rsp_o.data.increment        = inc_q;
  assign rsp_o.data.second_increment = inc2_q;
  assign rsp_o.data.bad_request      = bad_q;

endmodule
